@@ hdl/pfc_pkg.sv @@
package pfc_pkg;

    // format codes
    localparam logic [2:0] FMT_GRAY8   = 3'd0;
    localparam logic [2:0] FMT_GRAY16  = 3'd1;
    localparam logic [2:0] FMT_SGRAY16 = 3'd2;
    localparam logic [2:0] FMT_RGB24   = 3'd3;
    localparam logic [2:0] FMT_RGBA32  = 3'd4;
    localparam logic [2:0] FMT_BGRA32  = 3'd5;
    localparam logic [2:0] FMT_RGB48   = 3'd6;

    // configuration register indexes
    localparam logic [0:0] CFG_SOURCE_FORMAT = 1'b0;
    localparam logic [0:0] CFG_TARGET_FORMAT = 1'b1;

    // bt.709 luma weights, sum scaled by 10000
    localparam logic [11:0] LUMA_WR = 12'd2126;
    localparam logic [12:0] LUMA_WG = 13'd7152;
    localparam logic [9:0]  LUMA_WB = 10'd722;

    // reciprocal of 10000: ceil(2^40 / 10000), exact for sums up to 255 * 10000
    localparam int          RECIP_SHIFT = 40;
    localparam logic [26:0] RECIP_10000 = 27'd109951163;

    localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;
    localparam logic [15:0] SAT_U8       = 16'd255;
    localparam logic [15:0] SAT_S16      = 16'd32767;

    // conversion operation picked from the format pair
    typedef enum logic [4:0] {
        OP_BAD,
        OP_BYTE0,       // o0 = b0
        OP_WORD0,       // o0 = w0
        OP_RGB,         // b0 b1 b2
        OP_RGBA,        // b0 b1 b2 b3
        OP_COPY48,      // w0, high bytes of w1 w2
        OP_HIGH48,      // high bytes of w0 w1 w2
        OP_U16_TO_U8,   // saturate to 255
        OP_U16_TO_S16,  // saturate to 32767
        OP_S16_TO_U8,   // clamp signed to 0..255
        OP_S16_TO_U16,  // clamp signed to 0..32767
        OP_LUMA,
        OP_SWAP_RGB,    // b2 b1 b0
        OP_RGB_FILL_A,  // b0 b1 b2 255
        OP_SWAP_FILL_A, // b2 b1 b0 255
        OP_GRAY_REP,    // b0 b0 b0
        OP_GRAY_REP_A,  // b0 b0 b0 255
        OP_U16_REP_A,   // sat255 x3, 255
        OP_S16_REP_A    // clamp255 x3, 255
    } t_op;

    typedef struct packed {
        logic [15:0] chan0;
        logic [7:0]  chan1;
        logic [7:0]  chan2;
        logic [7:0]  chan3;
        logic        bad;
    } t_pix;

    // after decode and weight multiply
    typedef struct packed {
        t_op         op;
        logic [15:0] w0;
        logic [15:0] w1;
        logic [15:0] w2;
        logic [7:0]  a;
        logic [19:0] pr;
        logic [20:0] pg;
        logic [17:0] pb;
    } t_s1;

    // after channel routing and luma sum
    typedef struct packed {
        t_pix        pix;
        logic        luma;
        logic [21:0] sum;
    } t_s2;

    // after the reciprocal multiply
    typedef struct packed {
        t_pix       pix;
        logic       luma;
        logic [7:0] q;
    } t_s3;

    function automatic t_op f_decode(input logic [2:0] s, input logic [2:0] t);
        t_op op;
        op = OP_BAD;
        if (s == t) begin
            case (s)
                FMT_GRAY8:   op = OP_BYTE0;
                FMT_GRAY16:  op = OP_WORD0;
                FMT_SGRAY16: op = OP_WORD0;
                FMT_RGB24:   op = OP_RGB;
                FMT_RGBA32:  op = OP_RGBA;
                FMT_BGRA32:  op = OP_RGBA;
                FMT_RGB48:   op = OP_COPY48;
                default:     op = OP_BAD;
            endcase
        end else if (s == FMT_GRAY8 && (t == FMT_GRAY16 || t == FMT_SGRAY16)) begin
            op = OP_BYTE0;
        end else if (s == FMT_GRAY16 && t == FMT_GRAY8) begin
            op = OP_U16_TO_U8;
        end else if (s == FMT_GRAY16 && t == FMT_SGRAY16) begin
            op = OP_U16_TO_S16;
        end else if (s == FMT_SGRAY16 && t == FMT_GRAY8) begin
            op = OP_S16_TO_U8;
        end else if (s == FMT_SGRAY16 && t == FMT_GRAY16) begin
            op = OP_S16_TO_U16;
        end else if (s == FMT_RGB24 &&
                     (t == FMT_GRAY8 || t == FMT_GRAY16 || t == FMT_SGRAY16)) begin
            op = OP_LUMA;
        end else if (s == FMT_RGBA32 && t == FMT_GRAY8) begin
            op = OP_LUMA;
        end else if (s == FMT_RGBA32 && t == FMT_RGB24) begin
            op = OP_RGB;
        end else if (s == FMT_BGRA32 && t == FMT_RGB24) begin
            op = OP_SWAP_RGB;
        end else if (s == FMT_RGB24 && t == FMT_RGBA32) begin
            op = OP_RGB_FILL_A;
        end else if (s == FMT_GRAY8 && t == FMT_RGB24) begin
            op = OP_GRAY_REP;
        end else if (s == FMT_GRAY8 && t == FMT_RGBA32) begin
            op = OP_GRAY_REP_A;
        end else if (s == FMT_GRAY16 && t == FMT_BGRA32) begin
            op = OP_U16_REP_A;
        end else if (s == FMT_SGRAY16 && t == FMT_BGRA32) begin
            op = OP_S16_REP_A;
        end else if (s == FMT_RGB24 && t == FMT_BGRA32) begin
            op = OP_SWAP_FILL_A;
        end else if (s == FMT_RGB48 && t == FMT_RGB24) begin
            op = OP_HIGH48;
        end
        return op;
    endfunction

endpackage

@@ hdl/pfc_decode.sv @@
module pfc_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [2:0]    i_src_fmt,
    input  logic [2:0]    i_tgt_fmt,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [15:0]   i_chan0,
    input  logic [15:0]   i_chan1,
    input  logic [15:0]   i_chan2,
    input  logic [7:0]    i_chan3,
    output logic          o_valid,
    input  logic          i_ready,
    output pfc_pkg::t_s1  o_data
);
    import pfc_pkg::*;

    logic r_valid;
    t_s1  r_data;
    t_s1  n_data;

    assign o_ready = !r_valid || i_ready;

    // pick the operation and start the luma weights
    always_comb begin
        n_data.op = f_decode(i_src_fmt, i_tgt_fmt);
        n_data.w0 = i_chan0;
        n_data.w1 = i_chan1;
        n_data.w2 = i_chan2;
        n_data.a  = i_chan3;
        n_data.pr = 20'(i_chan0[7:0]) * 20'(LUMA_WR);
        n_data.pg = 21'(i_chan1[7:0]) * 21'(LUMA_WG);
        n_data.pb = 18'(i_chan2[7:0]) * 18'(LUMA_WB);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ hdl/pfc_route.sv @@
module pfc_route (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  pfc_pkg::t_s1  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output pfc_pkg::t_s2  o_data
);
    import pfc_pkg::*;

    logic        r_valid;
    t_s2         r_data;
    t_s2         n_data;
    logic [7:0]  b0, b1, b2;
    logic [15:0] u16_sat8;
    logic [15:0] s16_sat8;
    logic [15:0] u16_sat15;
    logic [15:0] s16_sat15;

    assign o_ready = !r_valid || i_ready;

    assign b0 = i_data.w0[7:0];
    assign b1 = i_data.w1[7:0];
    assign b2 = i_data.w2[7:0];

    // gray saturation and signed clamps
    assign u16_sat8  = (i_data.w0 > SAT_U8) ? SAT_U8 : i_data.w0;
    assign s16_sat8  = i_data.w0[15] ? 16'd0 : u16_sat8;
    assign u16_sat15 = i_data.w0[15] ? SAT_S16 : i_data.w0;
    assign s16_sat15 = i_data.w0[15] ? 16'd0 : i_data.w0;

    // channel routing and luma sum
    always_comb begin
        n_data.pix.chan0 = 16'd0;
        n_data.pix.chan1 = 8'd0;
        n_data.pix.chan2 = 8'd0;
        n_data.pix.chan3 = 8'd0;
        n_data.pix.bad   = 1'b0;
        n_data.luma      = 1'b0;
        n_data.sum       = 22'(i_data.pr) + 22'(i_data.pg) + 22'(i_data.pb);
        case (i_data.op)
            OP_BYTE0: begin
                n_data.pix.chan0 = {8'd0, b0};
            end
            OP_WORD0: begin
                n_data.pix.chan0 = i_data.w0;
            end
            OP_RGB: begin
                n_data.pix.chan0 = {8'd0, b0};
                n_data.pix.chan1 = b1;
                n_data.pix.chan2 = b2;
            end
            OP_RGBA: begin
                n_data.pix.chan0 = {8'd0, b0};
                n_data.pix.chan1 = b1;
                n_data.pix.chan2 = b2;
                n_data.pix.chan3 = i_data.a;
            end
            OP_COPY48: begin
                n_data.pix.chan0 = i_data.w0;
                n_data.pix.chan1 = i_data.w1[15:8];
                n_data.pix.chan2 = i_data.w2[15:8];
            end
            OP_HIGH48: begin
                n_data.pix.chan0 = {8'd0, i_data.w0[15:8]};
                n_data.pix.chan1 = i_data.w1[15:8];
                n_data.pix.chan2 = i_data.w2[15:8];
            end
            OP_U16_TO_U8: begin
                n_data.pix.chan0 = u16_sat8;
            end
            OP_U16_TO_S16: begin
                n_data.pix.chan0 = u16_sat15;
            end
            OP_S16_TO_U8: begin
                n_data.pix.chan0 = s16_sat8;
            end
            OP_S16_TO_U16: begin
                n_data.pix.chan0 = s16_sat15;
            end
            OP_LUMA: begin
                n_data.luma = 1'b1;
            end
            OP_SWAP_RGB: begin
                n_data.pix.chan0 = {8'd0, b2};
                n_data.pix.chan1 = b1;
                n_data.pix.chan2 = b0;
            end
            OP_RGB_FILL_A: begin
                n_data.pix.chan0 = {8'd0, b0};
                n_data.pix.chan1 = b1;
                n_data.pix.chan2 = b2;
                n_data.pix.chan3 = ALPHA_OPAQUE;
            end
            OP_SWAP_FILL_A: begin
                n_data.pix.chan0 = {8'd0, b2};
                n_data.pix.chan1 = b1;
                n_data.pix.chan2 = b0;
                n_data.pix.chan3 = ALPHA_OPAQUE;
            end
            OP_GRAY_REP: begin
                n_data.pix.chan0 = {8'd0, b0};
                n_data.pix.chan1 = b0;
                n_data.pix.chan2 = b0;
            end
            OP_GRAY_REP_A: begin
                n_data.pix.chan0 = {8'd0, b0};
                n_data.pix.chan1 = b0;
                n_data.pix.chan2 = b0;
                n_data.pix.chan3 = ALPHA_OPAQUE;
            end
            OP_U16_REP_A: begin
                n_data.pix.chan0 = u16_sat8;
                n_data.pix.chan1 = u16_sat8[7:0];
                n_data.pix.chan2 = u16_sat8[7:0];
                n_data.pix.chan3 = ALPHA_OPAQUE;
            end
            OP_S16_REP_A: begin
                n_data.pix.chan0 = s16_sat8;
                n_data.pix.chan1 = s16_sat8[7:0];
                n_data.pix.chan2 = s16_sat8[7:0];
                n_data.pix.chan3 = ALPHA_OPAQUE;
            end
            default: begin
                n_data.pix.bad = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ hdl/pfc_scale.sv @@
module pfc_scale (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  pfc_pkg::t_s2  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output pfc_pkg::t_s3  o_data
);
    import pfc_pkg::*;

    logic        r_valid;
    t_s3         r_data;
    logic [48:0] prod;

    assign o_ready = !r_valid || i_ready;

    // divide the weighted sum by 10000 through the reciprocal
    assign prod = 49'(i_data.sum) * 49'(RECIP_10000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data.pix  <= i_data.pix;
            r_data.luma <= i_data.luma;
            r_data.q    <= prod[RECIP_SHIFT +: 8];
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ hdl/pixel_format_converter_core.sv @@
// Pixel format converter: one pixel in per transfer, one pixel out, in the
// format pair set by the source_format and target_format registers (gray8,
// gray16, signed gray16, rgb24, rgba32, bgra32, rgb48). It takes a pixel every
// clock while the output is not stalled and passes four register stages in
// order: decode with the luma weight multiplies, channel routing with the luma
// sum, the reciprocal multiply that divides by 10000, and the output register.
// Each stage stalls only while it holds a pixel the next one cannot take.
// A pair with no conversion gives zero channels with unsupported set.
// Write the format registers only while no pixel is in flight.
module pixel_format_converter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [0:0]  i_cfg_index,
    input  logic [2:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_in_chan0,
    input  logic [15:0] i_in_chan1,
    input  logic [15:0] i_in_chan2,
    input  logic [7:0]  i_in_chan3,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_out_chan0,
    output logic [7:0]  o_out_chan1,
    output logic [7:0]  o_out_chan2,
    output logic [7:0]  o_out_chan3,
    output logic        o_unsupported
);
    import pfc_pkg::*;

    logic [2:0] r_src_fmt;
    logic [2:0] r_tgt_fmt;

    logic s1_valid, s1_ready;
    t_s1  s1_data;
    logic s2_valid, s2_ready;
    t_s2  s2_data;
    logic s3_valid, s3_ready;
    t_s3  s3_data;

    logic r_out_valid;
    t_pix r_out;
    t_pix n_out;

    // format registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt <= FMT_GRAY8;
            r_tgt_fmt <= FMT_GRAY8;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SOURCE_FORMAT: r_src_fmt <= i_cfg_data;
                CFG_TARGET_FORMAT: r_tgt_fmt <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pfc_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_src_fmt (r_src_fmt),
        .i_tgt_fmt (r_tgt_fmt),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_chan0   (i_in_chan0),
        .i_chan1   (i_in_chan1),
        .i_chan2   (i_in_chan2),
        .i_chan3   (i_in_chan3),
        .o_valid   (s1_valid),
        .i_ready   (s1_ready),
        .o_data    (s1_data)
    );

    pfc_route u_route (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_data  (s2_data)
    );

    pfc_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_data  (s2_data),
        .o_valid (s3_valid),
        .i_ready (s3_ready),
        .o_data  (s3_data)
    );

    // output stage: merge the luma quotient into the routed pixel
    assign s3_ready = !r_out_valid || i_out_ready;

    always_comb begin
        n_out = s3_data.pix;
        if (s3_data.luma) begin
            n_out.chan0 = {8'd0, s3_data.q};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s3_ready) begin
            r_out_valid <= s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_ready && s3_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_chan0   = r_out.chan0;
    assign o_out_chan1   = r_out.chan1;
    assign o_out_chan2   = r_out.chan2;
    assign o_out_chan3   = r_out.chan3;
    assign o_unsupported = r_out.bad;

endmodule
